// ===== rtl/lrs_pkg.sv =====
// Shared constants, types and constant tables of the logistic regression SGD block.
package lrs_pkg;

	localparam int NUM_FEATURES    = 8;
	localparam int SIGMOID_ENTRIES = 256;

	localparam int FEAT_W    = 16;
	localparam int WEIGHT_W  = 32;
	localparam int W_DEPTH   = NUM_FEATURES + 1;
	localparam int ADDR_W    = $clog2(W_DEPTH);
	localparam int FIDX_W    = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
	localparam int LUT_IDX_W = $clog2(SIGMOID_ENTRIES);
	localparam int LR_W      = 24;

	// The bias is multiplied by 1.0 in Q1.15 so that it shares the feature datapath.
	localparam logic [FEAT_W:0] BIAS_SCALE = (FEAT_W + 1)'(32768);

	localparam logic [LR_W-1:0] LEARN_RATE_RESET = LR_W'(1678);

	localparam logic [1:0] ACT_PREDICT = 2'd0;
	localparam logic [1:0] ACT_TRAIN   = 2'd1;
	localparam logic [1:0] ACT_WRITE   = 2'd2;
	localparam logic [1:0] ACT_READ    = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WRITE,
		ST_READ,
		ST_READ_WAIT,
		ST_PASS1,
		ST_DRAIN1,
		ST_CLAMP,
		ST_LOOKUP,
		ST_STEP,
		ST_PASS2,
		ST_DRAIN2,
		ST_FINISH
	} lrs_state_t;

	typedef struct packed {
		logic                       we;
		logic [ADDR_W-1:0]          waddr;
		logic signed [WEIGHT_W-1:0] wdata;
		logic [ADDR_W-1:0]          raddr;
	} wmem_req_t;

	typedef logic [W_DEPTH-1:0][WEIGHT_W-1:0] init_arr_t;
	typedef logic [SIGMOID_ENTRIES-1:0][15:0] sig_lut_t;

	function automatic init_arr_t init_weights();
		init_arr_t w;
		w = '0;
		for (int i = 0; i < W_DEPTH; i++) begin
			case (i)
				0: w[i] = 32'sd6554;
				1: w[i] = 32'sd13107;
				2: w[i] = -32'sd6554;
				3: w[i] = 32'sd19661;
				4: w[i] = 32'sd32768;
				5: w[i] = 32'sd39322;
				6: w[i] = 32'sd45875;
				7: w[i] = -32'sd13107;
				8: w[i] = 32'sd19661;
				default: w[i] = '0;
			endcase
		end
		return w;
	endfunction

	// One table entry: sigmoid at the middle of its cell, via a short series for exp
	// and eight squarings, then a rounded quotient formed by long division.
	function automatic logic [15:0] sigmoid_entry(int i);
		longint      m;
		logic [63:0] a;
		logic [63:0] t;
		logic [63:0] u;
		logic [63:0] a2;
		logic [63:0] a3;
		logic [63:0] a4;
		logic [63:0] e;
		logic [63:0] d;
		logic [63:0] n;
		logic [63:0] q;
		logic [63:0] r;
		m  = 2 * longint'(i) + 1 - longint'(SIGMOID_ENTRIES);
		a  = (m < 0) ? 64'(-m) : 64'(m);
		t  = (a << 34) / SIGMOID_ENTRIES;
		u  = t >> 8;
		a2 = ((u * u) >> 31) / 2;
		a3 = ((a2 * u) >> 31) / 3;
		a4 = ((a3 * u) >> 31) / 4;
		e  = (64'd1 << 31) - u + a2 - a3 + a4;
		for (int k = 0; k < 8; k++) begin
			e = (e * e) >> 31;
		end
		d = (64'd1 << 31) + e;
		n = ((m >= 0) ? (64'd1 << 47) : (e << 16)) + (d >> 1);
		q = '0;
		r = '0;
		for (int k = 63; k >= 0; k--) begin
			r = {r[62:0], n[k]};
			if (r >= d) begin
				r    = r - d;
				q[k] = 1'b1;
			end
		end
		return (q > 64'd65535) ? 16'hFFFF : q[15:0];
	endfunction

	function automatic sig_lut_t sigmoid_table();
		sig_lut_t lut;
		for (int i = 0; i < SIGMOID_ENTRIES; i++) begin
			lut[i] = sigmoid_entry(i);
		end
		return lut;
	endfunction

	localparam init_arr_t INIT_W      = init_weights();
	localparam sig_lut_t  SIGMOID_LUT = sigmoid_table();

endpackage

// ===== rtl/lrs_wmem.sv =====
// Weight memory: synchronous single-port-write RAM with reset values supplied by valid bits.
module lrs_wmem (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  lrs_pkg::wmem_req_t                   req,
	output logic signed [lrs_pkg::WEIGHT_W-1:0]  rdata
);

	logic [lrs_pkg::WEIGHT_W-1:0] mem [lrs_pkg::W_DEPTH];
	logic [lrs_pkg::WEIGHT_W-1:0] mem_rd_q;
	logic [lrs_pkg::ADDR_W-1:0]   raddr_q;
	logic [lrs_pkg::W_DEPTH-1:0]  valid_q;
	logic                         rvalid_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		mem_rd_q <= mem[req.raddr];
		raddr_q  <= req.raddr;
	end

	// An entry never written since reset reads as its initial model value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (req.we) begin
				valid_q[req.waddr] <= 1'b1;
			end
			rvalid_q <= valid_q[req.raddr];
		end
	end

	assign rdata = rvalid_q ? mem_rd_q : lrs_pkg::INIT_W[raddr_q];

endmodule

// ===== rtl/logistic_regression_sgd.sv =====
// Top level of the logistic regression classifier with on-line SGD training.
//
// Holds a bias and eight Q16.16 weights in a small RAM and serves one item at a time.
// A predict item runs the dot-product pass, a drain, the clamp and the lookup; a train item
// then forms the step and runs the update pass and a drain. A weight write passes the write
// state, a weight read the read and read-wait states. Each item ends in the finish state,
// which loads the result; the next item is taken only once the block is back in idle. The
// weight RAM gives one weight per cycle, and one multiplier is shared between the dot-product
// pass and the update pass over all nine weights. A finished result is held in an output
// register, so the next item is taken while it waits; an item whose result is ready while
// the previous one is still held waits until that one is taken.
// The learning rate register may be written only while no item is in progress.
module logistic_regression_sgd (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [1:0]                           action,
	input  logic [3:0]                           weight_index,
	input  logic signed [31:0]                   weight_value,
	input  logic [15:0]                          feature_0,
	input  logic [15:0]                          feature_1,
	input  logic [15:0]                          feature_2,
	input  logic [15:0]                          feature_3,
	input  logic [15:0]                          feature_4,
	input  logic [15:0]                          feature_5,
	input  logic [15:0]                          feature_6,
	input  logic [15:0]                          feature_7,
	input  logic                                 label,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [15:0]                          probability,
	output logic                                 predicted_class,
	output logic signed [31:0]                   weight_out,
	output logic                                 saturated,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [23:0]                          cfg_data
);

	localparam int ADDR_W   = lrs_pkg::ADDR_W;
	localparam int FEAT_W   = lrs_pkg::FEAT_W;
	localparam int WEIGHT_W = lrs_pkg::WEIGHT_W;
	localparam int NF       = lrs_pkg::NUM_FEATURES;
	localparam int A_W      = 43;
	localparam int PROD_W   = A_W + FEAT_W + 2;
	localparam int NEW_W    = PROD_W + 1;
	localparam int ACC_W    = 52;
	localparam int UPD_SH   = 39;
	localparam int SUM_SH   = 35;
	localparam int SCALE_W  = 36 + lrs_pkg::LUT_IDX_W + 1;
	localparam int IDXF_W   = SCALE_W - SUM_SH;

	localparam logic [ADDR_W-1:0]       LAST_IDX   = ADDR_W'(NF);
	localparam logic signed [ACC_W-1:0] SUM_LIMIT  = ACC_W'(64'sd1 <<< 34);
	localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(64'sd1 <<< (UPD_SH - 1));
	localparam logic signed [NEW_W-1:0] W_MAX_X    = NEW_W'(64'sd2147483647);
	localparam logic signed [NEW_W-1:0] W_MIN_X    = NEW_W'(-64'sd2147483648);

	lrs_pkg::lrs_state_t state_q, state_d;
	lrs_pkg::wmem_req_t  mem_req;

	logic signed [WEIGHT_W-1:0] mem_rdata;
	logic                       issue;
	logic                       finish_load;
	logic                       accept;

	// Item held for the whole of its processing.
	logic [1:0]                 act_q;
	logic [ADDR_W-1:0]          widx_q;
	logic                       wrange_q;
	logic signed [WEIGHT_W-1:0] wval_q;
	logic [FEAT_W-1:0]          feat_q [NF];
	logic                       label_q;
	logic [FEAT_W-1:0]          feat_in [NF];

	logic [ADDR_W-1:0]          cnt_q;
	logic [lrs_pkg::LR_W-1:0]   learn_rate_q;

	// Read and multiply pipeline.
	logic                       v_s1, v_s2;
	logic                       pass2_s1, pass2_s2;
	logic [ADDR_W-1:0]          idx_s1, idx_s2;
	logic [FEAT_W:0]            f_s1;
	logic signed [PROD_W-1:0]   prod_s2;
	logic signed [WEIGHT_W-1:0] w_s2;
	logic [FEAT_W:0]            f_sel;
	logic signed [A_W-1:0]      mul_a;
	logic signed [FEAT_W+1:0]   mul_b;

	logic signed [ACC_W-1:0]    acc_q;
	logic [lrs_pkg::LUT_IDX_W-1:0] lut_idx_q;
	logic [15:0]                prob_q;
	logic signed [A_W-1:0]      step_q;
	logic signed [WEIGHT_W-1:0] wout_q;
	logic                       sat_q;

	logic [15:0]                probability_q;
	logic                       predicted_class_q;
	logic signed [WEIGHT_W-1:0] weight_out_q;
	logic                       saturated_q;
	logic                       out_valid_q;

	// Sum clamp and table index.
	logic                       clamp_hi, clamp_lo;
	logic signed [ACC_W-1:0]    clamped;
	logic signed [ACC_W-1:0]    clamped_off;
	logic [SCALE_W-1:0]         scaled;
	logic [IDXF_W-1:0]          idx_full;
	logic [lrs_pkg::LUT_IDX_W-1:0] lut_idx;

	// Error times learning rate.
	logic signed [17:0]         err;
	logic signed [A_W-1:0]      err_ext;
	logic signed [A_W-1:0]      lr_ext;
	logic signed [A_W-1:0]      step;

	// Weight update.
	logic signed [PROD_W-1:0]   upd_full;
	logic signed [NEW_W-1:0]    w_ext, u_ext, new_full;
	logic                       upd_hi, upd_lo;
	logic signed [WEIGHT_W-1:0] new_w;

	function automatic logic [lrs_pkg::FIDX_W-1:0] FIDX_CAST(logic [ADDR_W-1:0] c);
		logic [ADDR_W-1:0] d;
		d = c - ADDR_W'(1);
		return lrs_pkg::FIDX_W'(d);
	endfunction

	assign feat_in[0] = feature_0;
	assign feat_in[1] = feature_1;
	assign feat_in[2] = feature_2;
	assign feat_in[3] = feature_3;
	assign feat_in[4] = feature_4;
	assign feat_in[5] = feature_5;
	assign feat_in[6] = feature_6;
	assign feat_in[7] = feature_7;

	assign accept    = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	lrs_wmem u_wmem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mem_req),
		.rdata  (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lrs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		in_ready      = 1'b0;
		issue         = 1'b0;
		finish_load   = 1'b0;
		mem_req       = '0;
		mem_req.raddr = cnt_q;
		if (v_s2 && pass2_s2) begin
			mem_req.we    = 1'b1;
			mem_req.waddr = idx_s2;
			mem_req.wdata = new_w;
		end
		case (state_q)
			lrs_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (action)
						lrs_pkg::ACT_PREDICT, lrs_pkg::ACT_TRAIN: state_d = lrs_pkg::ST_PASS1;
						lrs_pkg::ACT_WRITE: state_d = lrs_pkg::ST_WRITE;
						default:            state_d = lrs_pkg::ST_READ;
					endcase
				end
			end
			lrs_pkg::ST_WRITE: begin
				mem_req.we    = wrange_q;
				mem_req.waddr = widx_q;
				mem_req.wdata = wval_q;
				state_d       = lrs_pkg::ST_FINISH;
			end
			lrs_pkg::ST_READ: begin
				mem_req.raddr = widx_q;
				state_d       = lrs_pkg::ST_READ_WAIT;
			end
			lrs_pkg::ST_READ_WAIT: state_d = lrs_pkg::ST_FINISH;
			lrs_pkg::ST_PASS1: begin
				issue = 1'b1;
				if (cnt_q == LAST_IDX) begin
					state_d = lrs_pkg::ST_DRAIN1;
				end
			end
			lrs_pkg::ST_DRAIN1: begin
				if (!v_s1 && !v_s2) begin
					state_d = lrs_pkg::ST_CLAMP;
				end
			end
			lrs_pkg::ST_CLAMP: state_d = lrs_pkg::ST_LOOKUP;
			lrs_pkg::ST_LOOKUP: begin
				state_d = (act_q == lrs_pkg::ACT_TRAIN) ? lrs_pkg::ST_STEP : lrs_pkg::ST_FINISH;
			end
			lrs_pkg::ST_STEP: state_d = lrs_pkg::ST_PASS2;
			lrs_pkg::ST_PASS2: begin
				issue = 1'b1;
				if (cnt_q == LAST_IDX) begin
					state_d = lrs_pkg::ST_DRAIN2;
				end
			end
			lrs_pkg::ST_DRAIN2: begin
				if (!v_s1 && !v_s2) begin
					state_d = lrs_pkg::ST_FINISH;
				end
			end
			lrs_pkg::ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					finish_load = 1'b1;
					state_d     = lrs_pkg::ST_IDLE;
				end
			end
			default: state_d = lrs_pkg::ST_IDLE;
		endcase
	end

	// Feature paired with the weight being read; index zero is the bias.
	assign f_sel = (cnt_q == '0) ? lrs_pkg::BIAS_SCALE
		: {1'b0, feat_q[FIDX_CAST(cnt_q)]};

	assign mul_a = pass2_s1 ? step_q : {{(A_W-WEIGHT_W){mem_rdata[WEIGHT_W-1]}}, mem_rdata};
	assign mul_b = {1'b0, f_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			out_valid_q  <= 1'b0;
			learn_rate_q <= lrs_pkg::LEARN_RATE_RESET;
		end else begin
			if (accept || (issue && cnt_q == LAST_IDX)) begin
				cnt_q <= '0;
			end else if (issue) begin
				cnt_q <= cnt_q + ADDR_W'(1);
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (finish_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid) begin
				learn_rate_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q    <= action;
			widx_q   <= ADDR_W'(weight_index);
			wrange_q <= (weight_index <= 4'(NF));
			wval_q   <= weight_value;
			feat_q   <= feat_in;
			label_q  <= label;
		end

		pass2_s1 <= (state_q == lrs_pkg::ST_PASS2);
		idx_s1   <= cnt_q;
		f_s1     <= f_sel;
		pass2_s2 <= pass2_s1;
		idx_s2   <= idx_s1;
		w_s2     <= mem_rdata;
		prod_s2  <= mul_a * mul_b;

		if (accept) begin
			acc_q  <= '0;
			prob_q <= '0;
			wout_q <= '0;
			sat_q  <= 1'b0;
		end else begin
			if (v_s2 && !pass2_s2) begin
				acc_q <= acc_q + ACC_W'(prod_s2);
			end
			if (state_q == lrs_pkg::ST_CLAMP) begin
				lut_idx_q <= lut_idx;
				if (clamp_hi || clamp_lo) begin
					sat_q <= 1'b1;
				end
			end
			if (state_q == lrs_pkg::ST_LOOKUP) begin
				prob_q <= lrs_pkg::SIGMOID_LUT[lut_idx_q];
			end
			if (state_q == lrs_pkg::ST_STEP) begin
				step_q <= step;
			end
			if (state_q == lrs_pkg::ST_READ_WAIT) begin
				wout_q <= wrange_q ? mem_rdata : '0;
			end
			if (v_s2 && pass2_s2 && (upd_hi || upd_lo)) begin
				sat_q <= 1'b1;
			end
		end

		if (finish_load) begin
			probability_q     <= prob_q;
			predicted_class_q <= (prob_q > 16'd32768);
			weight_out_q      <= wout_q;
			saturated_q       <= sat_q;
		end
	end

	// The sum is limited to plus or minus 8.0 before indexing the sigmoid table.
	assign clamp_hi    = acc_q > SUM_LIMIT;
	assign clamp_lo    = acc_q < -SUM_LIMIT;
	assign clamped     = clamp_hi ? SUM_LIMIT : (clamp_lo ? -SUM_LIMIT : acc_q);
	assign clamped_off = clamped + SUM_LIMIT;
	assign scaled      = SCALE_W'(clamped_off[35:0]) * SCALE_W'(lrs_pkg::SIGMOID_ENTRIES);
	assign idx_full    = scaled[SCALE_W-1:SUM_SH];
	assign lut_idx     = (idx_full >= IDXF_W'(lrs_pkg::SIGMOID_ENTRIES))
		? lrs_pkg::LUT_IDX_W'(lrs_pkg::SIGMOID_ENTRIES - 1)
		: idx_full[lrs_pkg::LUT_IDX_W-1:0];

	assign err     = $signed({2'b00, prob_q}) - $signed({1'b0, label_q, 16'b0});
	assign err_ext = {{(A_W-18){err[17]}}, err};
	assign lr_ext  = {{(A_W-lrs_pkg::LR_W){1'b0}}, learn_rate_q};
	assign step    = err_ext * lr_ext;

	// Round half up, subtract and saturate to the signed 32-bit range.
	assign upd_full = (prod_s2 + ROUND_HALF) >>> UPD_SH;
	assign w_ext    = {{(NEW_W-WEIGHT_W){w_s2[WEIGHT_W-1]}}, w_s2};
	assign u_ext    = {upd_full[PROD_W-1], upd_full};
	assign new_full = w_ext - u_ext;
	assign upd_hi   = new_full > W_MAX_X;
	assign upd_lo   = new_full < W_MIN_X;
	assign new_w    = upd_hi ? 32'sh7FFFFFFF : (upd_lo ? 32'sh80000000 : new_full[WEIGHT_W-1:0]);

	assign out_valid       = out_valid_q;
	assign probability     = probability_q;
	assign predicted_class = predicted_class_q;
	assign weight_out      = weight_out_q;
	assign saturated       = saturated_q;

endmodule

// ===== rtl/lrs_checker.sv =====
// Port-level checks of the logistic regression SGD block, bound to its top level.
module lrs_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [15:0]         probability,
	input logic                predicted_class,
	input logic signed [31:0]  weight_out,
	input logic                saturated
);

	// A held result must not change while it waits to be taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(probability) && $stable(weight_out))
		else $error("result changed while stalled");

	// The class always agrees with the probability it was derived from.
	a_class: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> predicted_class == (probability > 16'd32768))
		else $error("class does not match probability");

	// A read-back item carries no probability or saturation flag.
	a_read_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && weight_out != 32'sd0 |-> probability == 16'd0 && !saturated)
		else $error("read result mixed with prediction fields");

	// Items are served one at a time, so the input closes after an acceptance.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item accepted while busy");

endmodule

bind logistic_regression_sgd lrs_checker u_lrs_checker (.*);
